// ----- rtl/core/path_command_normalizer_unit_defines.svh -----
// Assertion macros shared by the normalizer RTL; clk and rst_n come from the using module.
`ifndef PATH_COMMAND_NORMALIZER_UNIT_DEFINES_SVH
`define PATH_COMMAND_NORMALIZER_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PCN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PCN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pcn_pkg.sv -----
package pcn_pkg;

    localparam logic [3:0] OP_MOVE    = 4'd0;
    localparam logic [3:0] OP_LINE    = 4'd1;
    localparam logic [3:0] OP_HORIZ   = 4'd2;
    localparam logic [3:0] OP_VERT    = 4'd3;
    localparam logic [3:0] OP_QUAD    = 4'd4;
    localparam logic [3:0] OP_SQUAD   = 4'd5;
    localparam logic [3:0] OP_CUBIC   = 4'd6;
    localparam logic [3:0] OP_SCUBIC  = 4'd7;
    localparam logic [3:0] OP_CLOSE   = 4'd8;
    localparam logic [3:0] OP_END     = 4'd9;
    localparam logic [3:0] OP_NONE    = 4'd15;

    localparam logic [2:0] KIND_BEGIN      = 3'd0;
    localparam logic [2:0] KIND_LINE       = 3'd1;
    localparam logic [2:0] KIND_QUAD       = 3'd2;
    localparam logic [2:0] KIND_CUBIC      = 3'd3;
    localparam logic [2:0] KIND_END_OPEN   = 3'd4;
    localparam logic [2:0] KIND_END_CLOSED = 3'd5;

    localparam int NUM_ARGS    = 6;
    localparam int NUM_POINTS  = 6;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [3:0] op;
        logic       rel;
        logic       reflect;
        logic       lead_valid;
        logic       lead_begin;
        logic       main_valid;
    } pcn_ctrl_t;

    localparam int CTRL_BITS = $bits(pcn_ctrl_t);

    typedef enum logic [1:0] {
        ST_FIRST  = 2'b01,
        ST_SECOND = 2'b10
    } pcn_back_state_t;

endpackage

// ----- rtl/core/path_command_normalizer_unit.sv -----
// Path command normalizer: takes one tokenized path command per word (opcode, relative and
// repeat flags, up to six signed coordinates) and returns absolute figure records, one per word
// on the record side, the last record of each command flagged final. A command is taken every
// cycle while the two-entry command queue has room; the back end turns out one record per cycle
// while records are taken, so a command that yields two records (a move while a figure is open,
// or a drawing command that opens a figure) holds the back end for both; commands that yield one
// record or none run at one per cycle. Commands pass through the queue and the record registers.
// Coordinate additions and smooth-curve reflections saturate to the signed coordinate range.
module path_command_normalizer_unit
    import pcn_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic [3:0]                   command,
    input  logic                         relative,
    input  logic                         repeat_req,
    input  logic signed [COORD_BITS-1:0] arg_a,
    input  logic signed [COORD_BITS-1:0] arg_b,
    input  logic signed [COORD_BITS-1:0] arg_c,
    input  logic signed [COORD_BITS-1:0] arg_d,
    input  logic signed [COORD_BITS-1:0] arg_e,
    input  logic signed [COORD_BITS-1:0] arg_f,
    output logic                         rec_valid,
    input  logic                         rec_ready,
    output logic [2:0]                   record_kind,
    output logic signed [COORD_BITS-1:0] point0_x,
    output logic signed [COORD_BITS-1:0] point0_y,
    output logic signed [COORD_BITS-1:0] point1_x,
    output logic signed [COORD_BITS-1:0] point1_y,
    output logic signed [COORD_BITS-1:0] point2_x,
    output logic signed [COORD_BITS-1:0] point2_y,
    output logic                         final_record
);

    localparam int ENTRY_BITS = CTRL_BITS + NUM_ARGS * COORD_BITS;

    logic                                push_valid, push_ready;
    pcn_ctrl_t                           push_ctrl, head_ctrl;
    logic [NUM_ARGS-1:0][COORD_BITS-1:0] push_args, head_args;
    logic                                head_valid, pop;
    logic [ENTRY_BITS-1:0]               head_data;

    pcn_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .command    (command),
        .relative   (relative),
        .repeat_req (repeat_req),
        .arg_a      (arg_a),
        .arg_b      (arg_b),
        .arg_c      (arg_c),
        .arg_d      (arg_d),
        .arg_e      (arg_e),
        .arg_f      (arg_f),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctrl  (push_ctrl),
        .push_args  (push_args)
    );

    pcn_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_ctrl, push_args}),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    assign head_ctrl = head_data[ENTRY_BITS-1 -: CTRL_BITS];
    assign head_args = head_data[NUM_ARGS*COORD_BITS-1:0];

    pcn_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_ctrl    (head_ctrl),
        .head_args    (head_args),
        .pop          (pop),
        .rec_valid    (rec_valid),
        .rec_ready    (rec_ready),
        .record_kind  (record_kind),
        .point0_x     (point0_x),
        .point0_y     (point0_y),
        .point1_x     (point1_x),
        .point1_y     (point1_y),
        .point2_x     (point2_x),
        .point2_y     (point2_y),
        .final_record (final_record)
    );

endmodule

// ----- rtl/core/pcn_front.sv -----
`include "path_command_normalizer_unit_defines.svh"

module pcn_front
    import pcn_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  logic [3:0]                            command,
    input  logic                                  relative,
    input  logic                                  repeat_req,
    input  logic signed [COORD_BITS-1:0]          arg_a,
    input  logic signed [COORD_BITS-1:0]          arg_b,
    input  logic signed [COORD_BITS-1:0]          arg_c,
    input  logic signed [COORD_BITS-1:0]          arg_d,
    input  logic signed [COORD_BITS-1:0]          arg_e,
    input  logic signed [COORD_BITS-1:0]          arg_f,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output pcn_ctrl_t                             push_ctrl,
    output logic [NUM_ARGS-1:0][COORD_BITS-1:0]   push_args
);

    logic [3:0] prev_op_reg, prev_op_next;
    logic       prev_rel_reg, prev_rel_next;
    logic       figure_open_reg, figure_open_next;
    logic [3:0] eff_op;
    logic       eff_rel;
    logic       drop;
    logic       keep;
    logic       accept;

    always_comb
    begin
        eff_op  = command;
        eff_rel = relative;
        if (repeat_req)
        begin
            eff_op  = (prev_op_reg == OP_MOVE) ? OP_LINE : prev_op_reg;
            eff_rel = prev_rel_reg;
        end
        drop = (eff_op > OP_END);

        push_ctrl            = '0;
        push_ctrl.op         = eff_op;
        push_ctrl.rel        = eff_rel;
        push_ctrl.reflect    = ((eff_op == OP_SQUAD) &&
                                ((prev_op_reg == OP_QUAD) || (prev_op_reg == OP_SQUAD))) ||
                               ((eff_op == OP_SCUBIC) &&
                                ((prev_op_reg == OP_CUBIC) || (prev_op_reg == OP_SCUBIC)));
        keep             = !drop;
        prev_op_next     = eff_op;
        prev_rel_next    = eff_rel;
        figure_open_next = 1'b1;

        case (eff_op)
            OP_END:
            begin
                push_ctrl.main_valid = figure_open_reg;
                prev_op_next         = OP_NONE;
                prev_rel_next        = 1'b0;
                figure_open_next     = 1'b0;
            end
            OP_CLOSE:
            begin
                push_ctrl.main_valid = 1'b1;
                keep                 = !drop && figure_open_reg;
                figure_open_next     = 1'b0;
            end
            OP_MOVE:
            begin
                push_ctrl.main_valid = 1'b1;
                push_ctrl.lead_valid = figure_open_reg;
                push_ctrl.lead_begin = 1'b0;
            end
            default:
            begin
                push_ctrl.main_valid = 1'b1;
                push_ctrl.lead_valid = !figure_open_reg;
                push_ctrl.lead_begin = 1'b1;
            end
        endcase
    end

    assign push_args  = {arg_f, arg_e, arg_d, arg_c, arg_b, arg_a};
    assign cmd_ready  = push_ready;
    assign push_valid = cmd_valid && keep;
    assign accept     = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_op_reg     <= OP_NONE;
            prev_rel_reg    <= 1'b0;
            figure_open_reg <= 1'b0;
        end
        else if (accept && !drop)
        begin
            prev_op_reg     <= prev_op_next;
            prev_rel_reg    <= prev_rel_next;
            figure_open_reg <= figure_open_next;
        end
    end

    `PCN_ASSERT_NOW(a_no_figure_without_op, prev_op_reg == OP_NONE, !figure_open_reg, "figure open with no previous command")

endmodule

// ----- rtl/core/pcn_queue.sv -----
`include "path_command_normalizer_unit_defines.svh"

module pcn_queue
    import pcn_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    input  logic             pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign push_ready = (count_reg != FULL_COUNT);
    assign push       = push_valid && push_ready;
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `PCN_ASSERT_NOW(a_no_pop_empty, pop, count_reg != '0, "pop from empty command queue")
    `PCN_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_COUNT, "command queue count out of range")

endmodule

// ----- rtl/core/pcn_back.sv -----
`include "path_command_normalizer_unit_defines.svh"

module pcn_back
    import pcn_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  pcn_ctrl_t                           head_ctrl,
    input  logic [NUM_ARGS-1:0][COORD_BITS-1:0] head_args,
    output logic                                pop,
    output logic                                rec_valid,
    input  logic                                rec_ready,
    output logic [2:0]                          record_kind,
    output logic signed [COORD_BITS-1:0]        point0_x,
    output logic signed [COORD_BITS-1:0]        point0_y,
    output logic signed [COORD_BITS-1:0]        point1_x,
    output logic signed [COORD_BITS-1:0]        point1_y,
    output logic signed [COORD_BITS-1:0]        point2_x,
    output logic signed [COORD_BITS-1:0]        point2_y,
    output logic                                final_record
);

    localparam int W = COORD_BITS;
    localparam logic [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? COORD_MIN : COORD_MAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] reflect(input logic [W-1:0] p, input logic [W-1:0] c);
        logic [W:0]   d;
        logic [W+1:0] s;
        d = {p[W-1], p} - {c[W-1], c};
        s = {{2{p[W-1]}}, p} + {d[W], d};
        if ((s[W+1:W-1] == 3'b000) || (s[W+1:W-1] == 3'b111))
        begin
            return s[W-1:0];
        end
        return s[W+1] ? COORD_MIN : COORD_MAX;
    endfunction

    pcn_back_state_t state_reg, state_next;

    logic [W-1:0] pen_x_reg, pen_y_reg, ctl_x_reg, ctl_y_reg;
    logic [W-1:0] pen_x_next, pen_y_next, ctl_x_next, ctl_y_next;

    logic         rec_valid_reg, rec_valid_next;
    logic [2:0]   kind_reg, kind_next;
    logic [W-1:0] pt_reg  [NUM_POINTS];
    logic [W-1:0] pt_next [NUM_POINTS];
    logic         final_reg, final_next;

    logic         can_load, step, lead_now, issue;
    logic [W-1:0] ox, oy;
    logic [W-1:0] sx0, sy1, sx2, sy3, sx4, sy5, sy0;
    logic [W-1:0] ref_x, ref_y;
    logic [W-1:0] mp  [NUM_POINTS];
    logic [W-1:0] end_x, end_y;
    logic [2:0]   main_kind;

    assign can_load = !rec_valid_reg || rec_ready;
    assign step     = head_valid && can_load;
    assign lead_now = head_ctrl.lead_valid && (state_reg == ST_FIRST);
    assign pop      = step && !lead_now;
    assign issue    = step && (lead_now || head_ctrl.main_valid);

    assign ox  = head_ctrl.rel ? pen_x_reg : '0;
    assign oy  = head_ctrl.rel ? pen_y_reg : '0;
    assign sx0 = sat_add(head_args[0], ox);
    assign sy1 = sat_add(head_args[1], oy);
    assign sx2 = sat_add(head_args[2], ox);
    assign sy3 = sat_add(head_args[3], oy);
    assign sx4 = sat_add(head_args[4], ox);
    assign sy5 = sat_add(head_args[5], oy);
    assign sy0 = sat_add(head_args[0], oy);

    assign ref_x = head_ctrl.reflect ? reflect(pen_x_reg, ctl_x_reg) : pen_x_reg;
    assign ref_y = head_ctrl.reflect ? reflect(pen_y_reg, ctl_y_reg) : pen_y_reg;

    // main record of the head command
    always_comb
    begin
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            mp[i] = '0;
        end
        end_x     = pen_x_reg;
        end_y     = pen_y_reg;
        main_kind = KIND_LINE;
        case (head_ctrl.op)
            OP_MOVE, OP_LINE:
            begin
                main_kind = (head_ctrl.op == OP_MOVE) ? KIND_BEGIN : KIND_LINE;
                mp[0] = sx0; mp[1] = sy1;
                end_x = sx0; end_y = sy1;
            end
            OP_HORIZ:
            begin
                mp[0] = sx0; mp[1] = pen_y_reg;
                end_x = sx0;
            end
            OP_VERT:
            begin
                mp[0] = pen_x_reg; mp[1] = sy0;
                end_y = sy0;
            end
            OP_QUAD:
            begin
                main_kind = KIND_QUAD;
                mp[0] = sx0; mp[1] = sy1; mp[2] = sx2; mp[3] = sy3;
                end_x = sx2; end_y = sy3;
            end
            OP_SQUAD:
            begin
                main_kind = KIND_QUAD;
                mp[0] = ref_x; mp[1] = ref_y; mp[2] = sx0; mp[3] = sy1;
                end_x = sx0; end_y = sy1;
            end
            OP_CUBIC:
            begin
                main_kind = KIND_CUBIC;
                mp[0] = sx0; mp[1] = sy1; mp[2] = sx2; mp[3] = sy3;
                mp[4] = sx4; mp[5] = sy5;
                end_x = sx4; end_y = sy5;
            end
            OP_SCUBIC:
            begin
                main_kind = KIND_CUBIC;
                mp[0] = ref_x; mp[1] = ref_y; mp[2] = sx0; mp[3] = sy1;
                mp[4] = sx2; mp[5] = sy3;
                end_x = sx2; end_y = sy3;
            end
            OP_CLOSE:
            begin
                main_kind = KIND_END_CLOSED;
            end
            default:
            begin
                main_kind = KIND_END_OPEN;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        ctl_x_next     = ctl_x_reg;
        ctl_y_next     = ctl_y_reg;
        rec_valid_next = rec_valid_reg;
        kind_next      = kind_reg;
        final_next     = final_reg;
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            pt_next[i] = pt_reg[i];
        end

        if (can_load)
        begin
            rec_valid_next = issue;
        end

        if (step && lead_now)
        begin
            state_next = ST_SECOND;
            final_next = 1'b0;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                pt_next[i] = '0;
            end
            if (head_ctrl.lead_begin)
            begin
                kind_next  = KIND_BEGIN;
                pt_next[0] = pen_x_reg;
                pt_next[1] = pen_y_reg;
            end
            else
            begin
                kind_next = KIND_END_OPEN;
            end
        end
        else if (pop)
        begin
            state_next = ST_FIRST;
            final_next = 1'b1;
            kind_next  = main_kind;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                pt_next[i] = mp[i];
            end
            case (head_ctrl.op)
                OP_END:
                begin
                    pen_x_next = '0;
                    pen_y_next = '0;
                    ctl_x_next = '0;
                    ctl_y_next = '0;
                end
                OP_CLOSE:
                begin
                    pen_x_next = pen_x_reg;
                end
                OP_QUAD, OP_SQUAD:
                begin
                    pen_x_next = end_x;
                    pen_y_next = end_y;
                    ctl_x_next = mp[0];
                    ctl_y_next = mp[1];
                end
                OP_CUBIC, OP_SCUBIC:
                begin
                    pen_x_next = end_x;
                    pen_y_next = end_y;
                    ctl_x_next = mp[2];
                    ctl_y_next = mp[3];
                end
                default:
                begin
                    pen_x_next = end_x;
                    pen_y_next = end_y;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FIRST;
            rec_valid_reg <= 1'b0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            ctl_x_reg     <= '0;
            ctl_y_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rec_valid_reg <= rec_valid_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            ctl_x_reg     <= ctl_x_next;
            ctl_y_reg     <= ctl_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        final_reg <= final_next;
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            pt_reg[i] <= pt_next[i];
        end
    end

    assign rec_valid    = rec_valid_reg;
    assign record_kind  = kind_reg;
    assign point0_x     = pt_reg[0];
    assign point0_y     = pt_reg[1];
    assign point1_x     = pt_reg[2];
    assign point1_y     = pt_reg[3];
    assign point2_x     = pt_reg[4];
    assign point2_y     = pt_reg[5];
    assign final_record = final_reg;

    `PCN_ASSERT_NOW(a_second_has_head, state_reg == ST_SECOND, head_valid && head_ctrl.lead_valid, "second record pending without its command")
    `PCN_ASSERT_NEXT(a_lead_not_final, step && lead_now, rec_valid_reg && !final_reg && (state_reg == ST_SECOND), "leading record marked final")

endmodule

// ----- verif/tb.sv -----
module tb;
    import pcn_pkg::*;

    localparam logic [31:0] CMAX = 32'h7fff_ffff;
    localparam logic [31:0] CMIN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam longint CMAX_L = 64'sd2147483647;
    localparam longint CMIN_L = -CMAX_L - 1;
    localparam int RANDOM_WORDS = 500;

    typedef struct packed {
        logic [3:0]                  op;
        logic                        rel;
        logic                        rpt;
        logic [NUM_ARGS-1:0][31:0]   arg;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]                  kind;
        logic [NUM_POINTS-1:0][31:0] pt;
        logic                        fin;
    } record_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    logic [3:0]         command = OP_NONE;
    logic               relative = 1'b0;
    logic               repeat_req = 1'b0;
    logic signed [31:0] arg_a = '0;
    logic signed [31:0] arg_b = '0;
    logic signed [31:0] arg_c = '0;
    logic signed [31:0] arg_d = '0;
    logic signed [31:0] arg_e = '0;
    logic signed [31:0] arg_f = '0;
    logic               rec_valid;
    logic               rec_ready = 1'b0;
    logic [2:0]         record_kind;
    logic signed [31:0] point0_x;
    logic signed [31:0] point0_y;
    logic signed [31:0] point1_x;
    logic signed [31:0] point1_y;
    logic signed [31:0] point2_x;
    logic signed [31:0] point2_y;
    logic               final_record;

    cmd_word_t command_q[$];
    record_t   pending_records[$];
    cmd_word_t shown;
    record_t   due;

    longint     pen_x, pen_y, ctl_x, ctl_y;
    logic [3:0] last_op = OP_NONE;
    logic       last_rel = 1'b0;
    bit         fig_open = 1'b0;

    int fail_count = 0;
    int real_words = 0;
    int words_accepted = 0;
    int records_checked = 0;
    int kind_seen[8];
    int cyc = 0;
    wire burst = (cyc >= 300 && cyc < 650);

    path_command_normalizer_unit dut (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #4000000;
        $display("tb: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    function automatic longint clamp_coord(longint v);
        if (v > CMAX_L)
            return CMAX_L;
        if (v < CMIN_L)
            return CMIN_L;
        return v;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        return clamp_coord(a + b);
    endfunction

    function automatic longint mirror(longint p, longint c);
        return clamp_coord(2 * p - c);
    endfunction

    function automatic record_t make_record(logic [2:0] kind, longint p0x, longint p0y,
                                            longint p1x, longint p1y, longint p2x,
                                            longint p2y);
        record_t r;
        r.kind = kind;
        r.pt[0] = p0x[31:0];
        r.pt[1] = p0y[31:0];
        r.pt[2] = p1x[31:0];
        r.pt[3] = p1y[31:0];
        r.pt[4] = p2x[31:0];
        r.pt[5] = p2y[31:0];
        r.fin = 1'b0;
        return r;
    endfunction

    function automatic void normalize_command(cmd_word_t w);
        logic [3:0] op;
        logic       rel;
        longint     a[NUM_ARGS];
        longint     p[NUM_POINTS];
        longint     ox, oy, ex, ey;
        logic [2:0] kind;
        record_t    recs[$];
        op = w.op;
        rel = w.rel;
        ox = 0;
        oy = 0;
        ex = 0;
        ey = 0;
        if (w.rpt)
        begin
            if (last_op == OP_NONE)
                return;
            op = last_op;
            rel = last_rel;
            if (op == OP_MOVE)
                op = OP_LINE;
        end
        if (op > OP_END)
            return;
        for (int i = 0; i < NUM_ARGS; i++)
        begin
            a[i] = longint'($signed(w.arg[i]));
            p[i] = 0;
        end
        if (rel)
        begin
            ox = pen_x;
            oy = pen_y;
        end
        case (op)
            OP_END:
            begin
                if (fig_open)
                    recs.insert(recs.size(), make_record(KIND_END_OPEN, 0, 0, 0, 0, 0, 0));
                pen_x = 0;
                pen_y = 0;
                ctl_x = 0;
                ctl_y = 0;
                last_op = OP_NONE;
                last_rel = 1'b0;
                fig_open = 1'b0;
            end
            OP_CLOSE:
            begin
                if (fig_open)
                    recs.insert(recs.size(), make_record(KIND_END_CLOSED, 0, 0, 0, 0, 0, 0));
                fig_open = 1'b0;
            end
            OP_MOVE:
            begin
                if (fig_open)
                    recs.insert(recs.size(), make_record(KIND_END_OPEN, 0, 0, 0, 0, 0, 0));
                pen_x = add_sat(a[0], ox);
                pen_y = add_sat(a[1], oy);
                recs.insert(recs.size(), make_record(KIND_BEGIN, pen_x, pen_y, 0, 0, 0, 0));
                fig_open = 1'b1;
            end
            default:
            begin
                kind = KIND_LINE;
                case (op)
                    OP_LINE:
                    begin
                        ex = add_sat(a[0], ox);
                        ey = add_sat(a[1], oy);
                        p[0] = ex;
                        p[1] = ey;
                    end
                    OP_HORIZ:
                    begin
                        ex = add_sat(a[0], ox);
                        ey = pen_y;
                        p[0] = ex;
                        p[1] = ey;
                    end
                    OP_VERT:
                    begin
                        ex = pen_x;
                        ey = add_sat(a[0], oy);
                        p[0] = ex;
                        p[1] = ey;
                    end
                    OP_QUAD, OP_SQUAD:
                    begin
                        kind = KIND_QUAD;
                        if (op == OP_QUAD)
                        begin
                            p[0] = add_sat(a[0], ox);
                            p[1] = add_sat(a[1], oy);
                            ex = add_sat(a[2], ox);
                            ey = add_sat(a[3], oy);
                        end
                        else
                        begin
                            if (last_op == OP_QUAD || last_op == OP_SQUAD)
                            begin
                                p[0] = mirror(pen_x, ctl_x);
                                p[1] = mirror(pen_y, ctl_y);
                            end
                            else
                            begin
                                p[0] = pen_x;
                                p[1] = pen_y;
                            end
                            ex = add_sat(a[0], ox);
                            ey = add_sat(a[1], oy);
                        end
                        p[2] = ex;
                        p[3] = ey;
                        ctl_x = p[0];
                        ctl_y = p[1];
                    end
                    default:
                    begin
                        kind = KIND_CUBIC;
                        if (op == OP_CUBIC)
                        begin
                            p[0] = add_sat(a[0], ox);
                            p[1] = add_sat(a[1], oy);
                            p[2] = add_sat(a[2], ox);
                            p[3] = add_sat(a[3], oy);
                            ex = add_sat(a[4], ox);
                            ey = add_sat(a[5], oy);
                        end
                        else
                        begin
                            if (last_op == OP_CUBIC || last_op == OP_SCUBIC)
                            begin
                                p[0] = mirror(pen_x, ctl_x);
                                p[1] = mirror(pen_y, ctl_y);
                            end
                            else
                            begin
                                p[0] = pen_x;
                                p[1] = pen_y;
                            end
                            p[2] = add_sat(a[0], ox);
                            p[3] = add_sat(a[1], oy);
                            ex = add_sat(a[2], ox);
                            ey = add_sat(a[3], oy);
                        end
                        p[4] = ex;
                        p[5] = ey;
                        ctl_x = p[2];
                        ctl_y = p[3];
                    end
                endcase
                if (!fig_open)
                begin
                    recs.insert(recs.size(), make_record(KIND_BEGIN, pen_x, pen_y, 0, 0, 0, 0));
                    fig_open = 1'b1;
                end
                recs.insert(recs.size(), make_record(kind, p[0], p[1], p[2], p[3], p[4], p[5]));
                pen_x = ex;
                pen_y = ey;
            end
        endcase
        if (op != OP_END)
        begin
            last_op = op;
            last_rel = rel;
        end
        if (recs.size() > 0)
            recs[recs.size() - 1].fin = 1'b1;
        foreach (recs[i])
            pending_records.insert(pending_records.size(), recs[i]);
    endfunction

    task automatic queue_word(logic [3:0] op, logic rel, logic rpt,
                              logic [31:0] a0 = '0, logic [31:0] a1 = '0,
                              logic [31:0] a2 = '0, logic [31:0] a3 = '0,
                              logic [31:0] a4 = '0, logic [31:0] a5 = '0);
        cmd_word_t w;
        w.op = op;
        w.rel = rel;
        w.rpt = rpt;
        w.arg[0] = a0;
        w.arg[1] = a1;
        w.arg[2] = a2;
        w.arg[3] = a3;
        w.arg[4] = a4;
        w.arg[5] = a5;
        command_q.insert(command_q.size(), w);
        if (rpt || op <= OP_END)
            real_words++;
    endtask

    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return $urandom_range(0, 32'd26214400) - 32'd13107200;
        if (sel < 8)
            return $urandom();
        if (sel == 8)
        begin
            case ($urandom_range(3))
                0: return CMAX;
                1: return CMIN;
                2: return '0;
                default: return '1;
            endcase
        end
        if ($urandom_range(1) == 1)
            return CMAX - $urandom_range(4 * ONE);
        return CMIN + $urandom_range(4 * ONE);
    endfunction

    task automatic queue_random(logic [3:0] op, logic rpt);
        queue_word(op, 1'($urandom_range(1)), rpt, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic add_random_figure();
        int pick;
        if ($urandom_range(99) < 85)
            queue_random(OP_MOVE, 1'b0);
        if ($urandom_range(99) < 15)
            queue_random(4'($urandom_range(OP_NONE)), 1'b1);
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(99) < 20)
                queue_random(4'($urandom_range(OP_NONE)), 1'b1);
            else
                queue_random(4'($urandom_range(OP_LINE, OP_SCUBIC)), 1'b0);
        end
        pick = $urandom_range(99);
        if (pick < 40)
            queue_random(OP_CLOSE, 1'b0);
        else if (pick < 50)
            queue_random(OP_END, 1'b0);
        else if (pick < 60)
        begin
            queue_random(OP_CLOSE, 1'b0);
            queue_random(4'($urandom_range(OP_LINE, OP_SCUBIC)), 1'b0);
        end
        if ($urandom_range(99) < 6)
            queue_random(4'($urandom_range(OP_END + 1, OP_NONE)), 1'b0);
        if ($urandom_range(99) < 4)
            queue_random(OP_CLOSE, 1'b0);
        if ($urandom_range(99) < 3)
            queue_random(OP_END, 1'b0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                normalize_command(shown);
                words_accepted++;
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (command_q.size() > 0 && (burst || $urandom_range(99) >= 34))
                begin
                    shown = command_q.pop_front();
                    cmd_valid <= 1'b1;
                    command <= shown.op;
                    relative <= shown.rel;
                    repeat_req <= shown.rpt;
                    arg_a <= shown.arg[0];
                    arg_b <= shown.arg[1];
                    arg_c <= shown.arg[2];
                    arg_d <= shown.arg[3];
                    arg_e <= shown.arg[4];
                    arg_f <= shown.arg[5];
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_ready <= 1'b0;
        else
            rec_ready <= burst || $urandom_range(99) >= 34;
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rec_valid && rec_ready)
        begin
            if (pending_records.size() == 0)
            begin
                $error("record_kind: expected no word, got %h", record_kind);
                fail_count++;
            end
            else
            begin
                due = pending_records.pop_front();
                check_field("record_kind", {29'd0, due.kind}, {29'd0, record_kind});
                check_field("point0_x", due.pt[0], point0_x);
                check_field("point0_y", due.pt[1], point0_y);
                check_field("point1_x", due.pt[2], point1_x);
                check_field("point1_y", due.pt[3], point1_y);
                check_field("point2_x", due.pt[4], point2_x);
                check_field("point2_y", due.pt[5], point2_y);
                check_field("final_record", {31'd0, due.fin}, {31'd0, final_record});
                records_checked++;
                kind_seen[due.kind]++;
            end
        end
    end

    initial
    begin
        pen_x = 0;
        pen_y = 0;
        ctl_x = 0;
        ctl_y = 0;
        queue_word(OP_LINE, 1'b0, 1'b1, ONE, ONE);
        queue_word(4'(OP_END + 1), 1'b0, 1'b0, ONE, ONE);
        queue_word(OP_NONE, 1'b1, 1'b0, ONE, ONE);
        queue_word(OP_LINE, 1'b0, 1'b0, 100 * ONE, 50 * ONE);
        queue_word(OP_HORIZ, 1'b1, 1'b0, -30 * ONE);
        queue_word(OP_VERT, 1'b1, 1'b0, 32'h0000_8000);
        queue_word(OP_MOVE, 1'b0, 1'b0, CMAX, CMIN);
        queue_word(OP_LINE, 1'b1, 1'b0, CMAX, CMIN);
        queue_word(OP_LINE, 1'b1, 1'b0, CMIN, CMAX);
        queue_word(OP_LINE, 1'b0, 1'b0, CMAX, CMIN);
        queue_word(OP_QUAD, 1'b0, 1'b0, CMIN, CMAX, CMAX, CMIN);
        queue_word(OP_SQUAD, 1'b0, 1'b0, '0, '0);
        queue_word(OP_SQUAD, 1'b1, 1'b0, 3 * ONE, -2 * ONE);
        queue_word(OP_LINE, 1'b0, 1'b0, 7 * ONE, 9 * ONE);
        queue_word(OP_SQUAD, 1'b0, 1'b0, 12 * ONE, 4 * ONE);
        queue_word(OP_CUBIC, 1'b1, 1'b0, ONE, 2 * ONE, 3 * ONE, '1, CMAX, CMIN);
        queue_word(OP_SCUBIC, 1'b0, 1'b0, 5 * ONE, 6 * ONE, 8 * ONE, 2 * ONE);
        queue_word(OP_SCUBIC, 1'b0, 1'b1, -ONE, ONE, -4 * ONE, 3 * ONE);
        queue_word(OP_CLOSE, 1'b0, 1'b0);
        queue_word(OP_CLOSE, 1'b1, 1'b0);
        queue_word(OP_SCUBIC, 1'b1, 1'b0, ONE, ONE, 2 * ONE, 2 * ONE);
        queue_word(OP_MOVE, 1'b1, 1'b0, -10 * ONE, 20 * ONE);
        queue_word(OP_NONE, 1'b0, 1'b1, 4 * ONE, -ONE);
        queue_word(OP_END, 1'b0, 1'b0);
        queue_word(OP_END, 1'b0, 1'b0);
        queue_word(OP_MOVE, 1'b0, 1'b1, ONE, ONE);
        while (real_words < 25 + RANDOM_WORDS)
            add_random_figure();

        while (command_q.size() != 0 || cmd_valid)
            @(posedge clk);
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("summary: %0d command words accepted, %0d records compared",
                 words_accepted, records_checked);
        $display("records by kind: begin %0d, line %0d, quad %0d, cubic %0d, open %0d, closed %0d",
                 kind_seen[KIND_BEGIN], kind_seen[KIND_LINE], kind_seen[KIND_QUAD],
                 kind_seen[KIND_CUBIC], kind_seen[KIND_END_OPEN], kind_seen[KIND_END_CLOSED]);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

// ----- path_command_normalizer_unit.f -----
+incdir+rtl/core
rtl/core/pcn_pkg.sv
rtl/core/pcn_front.sv
rtl/core/pcn_queue.sv
rtl/core/pcn_back.sv
rtl/core/path_command_normalizer_unit.sv
verif/tb.sv
